[design/cbor_tok_pkg.sv]
package cbor_tok_pkg;

    localparam int DEF_STACK_DEPTH = 16;
    localparam logic [4:0] MAX_NEST_RST = 5'd16;

    typedef enum logic [4:0] {
        PH_HEAD    = 5'b00001,
        PH_ARG     = 5'b00010,
        PH_PAYLOAD = 5'b00100,
        PH_TAGGED  = 5'b01000,
        PH_SINK    = 5'b10000
    } t_phase;

    // major types
    localparam logic [2:0] MT_UINT   = 3'd0;
    localparam logic [2:0] MT_NEG    = 3'd1;
    localparam logic [2:0] MT_BYTES  = 3'd2;
    localparam logic [2:0] MT_TEXT   = 3'd3;
    localparam logic [2:0] MT_ARRAY  = 3'd4;
    localparam logic [2:0] MT_MAP    = 3'd5;
    localparam logic [2:0] MT_TAG    = 3'd6;

    // additional info codes
    localparam logic [4:0] AI_U8      = 5'd24;
    localparam logic [4:0] AI_U64     = 5'd27;
    localparam logic [4:0] AI_INDEF   = 5'd31;
    localparam logic [4:0] AI_FALSE   = 5'd20;
    localparam logic [4:0] AI_TRUE    = 5'd21;
    localparam logic [4:0] AI_FLOAT16 = 5'd25;
    localparam logic [4:0] AI_FLOAT32 = 5'd26;
    localparam logic [4:0] AI_FLOAT64 = 5'd27;

    // token kinds
    localparam logic [3:0] TK_UINT    = 4'd0;
    localparam logic [3:0] TK_FALSE   = 4'd6;
    localparam logic [3:0] TK_TRUE    = 4'd7;
    localparam logic [3:0] TK_NULL    = 4'd8;
    localparam logic [3:0] TK_FLOAT16 = 4'd9;
    localparam logic [3:0] TK_FLOAT32 = 4'd10;
    localparam logic [3:0] TK_FLOAT64 = 4'd11;
    localparam logic [3:0] TK_PAYLOAD = 4'd12;
    localparam logic [3:0] TK_ERROR   = 4'd13;

    // error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_EOD   = 2'd1;
    localparam logic [1:0] ERR_INDEF = 2'd2;
    localparam logic [1:0] ERR_DEEP  = 2'd3;

endpackage

[design/cbor_stream_tokenizer_top.sv]
// a byte is held in the input register and its result is registered in the output register
// one byte per cycle unless i_ready stalls; unwind is a combinational search of open levels
// a byte that yields no token still takes its slot in the input register
// reset: synchronous active-low i_rst_n clears the parser and sets max_nesting to 16
// stack contents are not cleared, every level is written when it is opened
module cbor_stream_tokenizer_top
    import cbor_tok_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_token_kind,
    output logic [63:0] o_argument_value,
    output logic [7:0]  o_payload_byte,
    output logic [1:0]  o_error_code,
    output logic        o_top_done,
    output logic [4:0]  o_nesting_depth,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_max_nesting
);

    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int IW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW  = (SPW > 5) ? SPW : 5;

    logic [4:0]  r_max;

    logic        r_in_vld;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_major, n_major;
    logic [4:0]  r_info, n_info;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_left, n_left;
    logic [63:0] r_pl, n_pl;
    logic [SPW-1:0] r_sp, n_sp;

    logic [63:0] r_rem [STACK_DEPTH];
    logic [STACK_DEPTH-1:0] r_map;
    logic [STACK_DEPTH-1:0] r_val;

    logic        r_out_vld;
    logic [3:0]  r_kind;
    logic [63:0] r_arg;
    logic [7:0]  r_pay;
    logic [1:0]  r_err;
    logic        r_top;
    logic [4:0]  r_depth;

    logic        adv;
    logic        res_vld;
    logic [3:0]  res_kind;
    logic [63:0] res_arg;
    logic [7:0]  res_pay;
    logic [1:0]  res_err;
    logic        res_top;
    logic [4:0]  res_depth;
    logic        do_fin, do_cmp, do_push, is_err;
    logic [1:0]  err_code;

    logic [STACK_DEPTH-1:0] done;
    logic        found;
    logic [IW-1:0] cmp_t;
    logic [SPW-1:0] cmp_sp;
    logic [CW-1:0] limit, max_ext, depth_c;
    logic        at_limit;

    assign adv         = r_in_vld && (!r_out_vld || i_ready);
    assign o_ready     = !r_in_vld || adv;
    assign o_cfg_ready = 1'b1;

    // unwind search: highest open level that does not close with this item
    always_comb begin
        found = 1'b0;
        cmp_t = '0;
        for (int i = 0; i < STACK_DEPTH; i++) begin
            done[i] = (r_rem[i] == 64'd1) && (!r_map[i] || r_val[i]);
            if ((SPW'(i) < r_sp) && !done[i]) begin
                found = 1'b1;
                cmp_t = IW'(i);
            end
        end
        cmp_sp = found ? (SPW'(cmp_t) + SPW'(1)) : '0;
    end

    always_comb begin
        max_ext  = CW'(r_max);
        depth_c  = CW'(STACK_DEPTH);
        limit    = (max_ext < depth_c) ? max_ext : depth_c;
        at_limit = CW'(r_sp) >= limit;
    end

    always_comb begin
        n_phase  = r_phase;
        n_major  = r_major;
        n_info   = r_info;
        n_acc    = r_acc;
        n_left   = r_left;
        n_pl     = r_pl;
        n_sp     = r_sp;
        res_vld  = 1'b0;
        res_kind = TK_UINT;
        res_arg  = '0;
        res_pay  = '0;
        res_err  = ERR_NONE;
        res_top  = 1'b0;
        do_fin   = 1'b0;
        do_cmp   = 1'b0;
        do_push  = 1'b0;
        is_err   = 1'b0;
        err_code = ERR_NONE;

        case (r_phase)
            PH_SINK: begin
            end
            PH_ARG: begin
                n_acc  = {r_acc[55:0], r_in_byte};
                n_left = r_left - 4'd1;
                if (r_left == 4'd1) begin
                    do_fin = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                n_pl     = r_pl - 64'd1;
                res_vld  = 1'b1;
                res_kind = TK_PAYLOAD;
                res_pay  = r_in_byte;
                if (r_pl == 64'd1) begin
                    n_phase = PH_HEAD;
                    do_cmp  = 1'b1;
                end
            end
            default: begin
                n_major = r_in_byte[7:5];
                n_info  = r_in_byte[4:0];
                if (r_in_byte[4:0] < AI_U8) begin
                    n_acc  = 64'(r_in_byte[4:0]);
                    do_fin = 1'b1;
                end else if (r_in_byte[4:0] <= AI_U64) begin
                    n_acc   = '0;
                    n_left  = 4'd1 << r_in_byte[1:0];
                    n_phase = PH_ARG;
                end else if (r_in_byte[4:0] < AI_INDEF) begin
                    n_acc  = '0;
                    do_fin = 1'b1;
                end else begin
                    is_err   = 1'b1;
                    err_code = ERR_INDEF;
                end
            end
        endcase

        if (do_fin) begin
            n_phase = PH_HEAD;
            res_arg = n_acc;
            case (n_major)
                MT_UINT, MT_NEG: begin
                    res_vld  = 1'b1;
                    res_kind = {1'b0, n_major};
                    do_cmp   = 1'b1;
                end
                MT_BYTES, MT_TEXT: begin
                    res_vld  = 1'b1;
                    res_kind = {1'b0, n_major};
                    if (n_acc == 64'd0) begin
                        do_cmp = 1'b1;
                    end else begin
                        n_phase = PH_PAYLOAD;
                        n_pl    = n_acc;
                    end
                end
                MT_ARRAY, MT_MAP: begin
                    if (at_limit) begin
                        is_err   = 1'b1;
                        err_code = ERR_DEEP;
                    end else begin
                        res_vld  = 1'b1;
                        res_kind = {1'b0, n_major};
                        if (n_acc == 64'd0) begin
                            do_cmp = 1'b1;
                        end else begin
                            do_push = 1'b1;
                        end
                    end
                end
                MT_TAG: begin
                    n_phase = PH_TAGGED;
                end
                default: begin
                    res_vld = 1'b1;
                    do_cmp  = 1'b1;
                    case (n_info)
                        AI_FALSE:   res_kind = TK_FALSE;
                        AI_TRUE:    res_kind = TK_TRUE;
                        AI_FLOAT16: res_kind = TK_FLOAT16;
                        AI_FLOAT32: res_kind = TK_FLOAT32;
                        AI_FLOAT64: res_kind = TK_FLOAT64;
                        default:    res_kind = TK_NULL;
                    endcase
                end
            endcase
        end

        if (do_cmp) begin
            n_sp    = cmp_sp;
            res_top = !found;
        end
        if (do_push) begin
            n_sp = r_sp + SPW'(1);
        end

        if (is_err) begin
            n_phase  = PH_SINK;
            res_vld  = 1'b1;
            res_kind = TK_ERROR;
            res_arg  = '0;
            res_pay  = '0;
            res_err  = err_code;
            res_top  = 1'b0;
        end

        // end of data while an item is still open
        if (r_in_last && n_phase != PH_SINK && (n_phase != PH_HEAD || n_sp != '0)) begin
            res_vld  = 1'b1;
            res_kind = TK_ERROR;
            res_arg  = '0;
            res_pay  = '0;
            res_err  = ERR_EOD;
            res_top  = 1'b0;
        end

        res_depth = 5'(n_sp);

        if (r_in_last) begin
            n_phase = PH_HEAD;
            n_major = '0;
            n_info  = '0;
            n_acc   = '0;
            n_left  = '0;
            n_pl    = '0;
            n_sp    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max     <= MAX_NEST_RST;
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_phase   <= PH_HEAD;
            r_major   <= '0;
            r_info    <= '0;
            r_acc     <= '0;
            r_left    <= '0;
            r_pl      <= '0;
            r_sp      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_max <= i_cfg_max_nesting;
            end
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (adv) begin
                r_out_vld <= res_vld;
                r_phase   <= n_phase;
                r_major   <= n_major;
                r_info    <= n_info;
                r_acc     <= n_acc;
                r_left    <= n_left;
                r_pl      <= n_pl;
                r_sp      <= n_sp;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (adv && res_vld) begin
            r_kind  <= res_kind;
            r_arg   <= res_arg;
            r_pay   <= res_pay;
            r_err   <= res_err;
            r_top   <= res_top;
            r_depth <= res_depth;
        end
        for (int i = 0; i < STACK_DEPTH; i++) begin
            if (adv && do_push && r_sp == SPW'(i)) begin
                r_rem[i] <= n_acc;
                r_map[i] <= (n_major == MT_MAP);
                r_val[i] <= 1'b0;
            end else if (adv && do_cmp && found && cmp_t == IW'(i)) begin
                if (r_map[i] && !r_val[i]) begin
                    r_val[i] <= 1'b1;
                end else begin
                    r_val[i] <= 1'b0;
                    r_rem[i] <= r_rem[i] - 64'd1;
                end
            end
        end
    end

    assign o_valid          = r_out_vld;
    assign o_token_kind     = r_kind;
    assign o_argument_value = r_arg;
    assign o_payload_byte   = r_pay;
    assign o_error_code     = r_err;
    assign o_top_done       = r_top;
    assign o_nesting_depth  = r_depth;

endmodule
